[src/text_cell_dbcs_glyph_render_top_defines.svh]
// Assertion macros shared by the glyph render block.
`ifndef TEXT_CELL_DBCS_GLYPH_RENDER_TOP_DEFINES_SVH
`define TEXT_CELL_DBCS_GLYPH_RENDER_TOP_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define TCDG_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger.
`define TCDG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/tcdg_pkg.sv]
// Shared constants and types of the double-byte text glyph renderer.
`timescale 1ns / 1ps

package tcdg_pkg;

    // Font geometry.
    localparam int CELL_ROWS       = 19;
    localparam int WIDE_GLYPH_ROWS = 16;

    // Field widths.
    localparam int CODE_W = 8;
    localparam int ROW_W  = 5;
    localparam int PAIR_W = 2 * CODE_W;
    localparam int PIX_W  = 64;
    localparam int CNT_W  = 5;

    // Store sizes and address widths.
    localparam int PAIR_DEPTH = 1 << PAIR_W;
    localparam int SF_DEPTH   = 256 * CELL_ROWS;
    localparam int SF_AW      = $clog2(SF_DEPTH);
    localparam int DF_DEPTH   = PAIR_DEPTH * 2 * WIDE_GLYPH_ROWS;
    localparam int DF_AW      = $clog2(DF_DEPTH);

    // Pair table entry: defined flag over one written bit per double-byte font row.
    localparam int WR_W  = 2 * WIDE_GLYPH_ROWS;
    localparam int PM_W  = WR_W + 1;
    localparam int WRI_W = $clog2(WR_W);
    localparam int HRI_W = $clog2(WIDE_GLYPH_ROWS);

    // Command codes.
    localparam logic [1:0] CMD_RENDER      = 2'd0;
    localparam logic [1:0] CMD_LOAD_SINGLE = 2'd1;
    localparam logic [1:0] CMD_LOAD_DOUBLE = 2'd2;

    // Glyph kind codes.
    localparam logic [1:0] KIND_SINGLE = 2'd0;
    localparam logic [1:0] KIND_LEFT   = 2'd1;
    localparam logic [1:0] KIND_RIGHT  = 2'd2;

    // Configuration register indexes.
    localparam logic REG_BLINK = 1'b0;
    localparam logic REG_WIDE  = 1'b1;

    // Pixel counts per result.
    localparam logic [CNT_W-1:0] NARROW_PIX = 5'd8;
    localparam logic [CNT_W-1:0] WIDE_PIX   = 5'd16;

    // One input beat.
    typedef struct packed {
        logic [1:0]        cmd;
        logic [CODE_W-1:0] char_code;
        logic [CODE_W-1:0] next_code;
        logic              next_valid;
        logic [7:0]        attr_byte;
        logic [ROW_W-1:0]  scanline;
        logic              cursor_here;
        logic              blink_phase;
        logic              half_select;
        logic [7:0]        glyph_bits;
        logic              mark_valid;
    } item_t;

    // Fetched glyph row with what the colour stage needs.
    typedef struct packed {
        logic [7:0] glyph;
        logic [1:0] kind;
        logic [7:0] attr;
        logic       cursor;
        logic       bphase;
    } glyph_rec_t;

    // Status of the fetch stage seen by the top level.
    typedef struct packed {
        logic clear_done;
        logic pending;
        logic busy;
    } fetch_status_t;

endpackage

[src/tcdg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tcdg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/tcdg_fetch.sv]
// Font and pair-table stores, clearing pass, read-modify-write and right-half tracking.
`timescale 1ns / 1ps

module tcdg_fetch (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  tcdg_pkg::item_t        in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output tcdg_pkg::glyph_rec_t   out_rec,
    output tcdg_pkg::fetch_status_t status
);

    // Single-byte font address: code times rows per cell plus row.
    function automatic logic [tcdg_pkg::SF_AW-1:0] sf_addr(
        input logic [tcdg_pkg::CODE_W-1:0] code,
        input logic [tcdg_pkg::ROW_W-1:0]  row
    );
        sf_addr = tcdg_pkg::SF_AW'(code) * tcdg_pkg::SF_AW'(tcdg_pkg::CELL_ROWS)
                + tcdg_pkg::SF_AW'(row);
    endfunction

    // Double-byte font address: pair and half select a glyph, then the row.
    function automatic logic [tcdg_pkg::DF_AW-1:0] df_addr(
        input logic [tcdg_pkg::PAIR_W-1:0] pair,
        input logic                        half,
        input logic [tcdg_pkg::ROW_W-1:0]  row
    );
        df_addr = tcdg_pkg::DF_AW'({pair, half})
                * tcdg_pkg::DF_AW'(tcdg_pkg::WIDE_GLYPH_ROWS)
                + tcdg_pkg::DF_AW'(row);
    endfunction

    // Clearing pass state.
    logic [tcdg_pkg::PAIR_W-1:0] clr_cnt_reg;
    logic                        clr_done_reg;

    // Stage 1: item whose store reads are in flight, with forwarded write data.
    logic                        s1_valid_reg;
    tcdg_pkg::item_t             s1_item_reg;
    logic [tcdg_pkg::CODE_W-1:0] s1_trail_reg;
    logic                        pm_hit_reg;
    logic [tcdg_pkg::PM_W-1:0]   pm_fwd_reg;
    logic                        sf_hit_reg;
    logic [7:0]                  sf_fwd_reg;
    logic                        df_hit_reg;
    logic [7:0]                  df_fwd_reg;

    // Right-half tracking.
    logic                                  pending_reg;
    logic [tcdg_pkg::PAIR_W-1:0]           held_pair_reg;
    logic [tcdg_pkg::WIDE_GLYPH_ROWS-1:0]  held_wr_reg;

    // Memory ports.
    logic                        pm_we, sf_we, df_we;
    logic [tcdg_pkg::PAIR_W-1:0] pm_waddr, pm_raddr;
    logic [tcdg_pkg::PM_W-1:0]   pm_wdata, pm_q;
    logic [tcdg_pkg::SF_AW-1:0]  sf_waddr, sf_raddr;
    logic [7:0]                  sf_wdata, sf_q;
    logic [tcdg_pkg::DF_AW-1:0]  df_waddr, df_raddr;
    logic [7:0]                  df_wdata, df_q;

    // Stage 1 decode.
    logic                        s1_render, s1_load_single, s1_load_double, s1_done;
    logic [tcdg_pkg::ROW_W-1:0]  s1_row;
    logic [tcdg_pkg::PAIR_W-1:0] s1_pair;
    logic [tcdg_pkg::PM_W-1:0]   pm_entry;
    logic                        s1_defined, row_in_sf, row_in_df;
    logic [7:0]                  sf_byte, df_byte;
    logic [tcdg_pkg::WRI_W-1:0]  s1_wr_idx, s1_wr_bit;
    logic [tcdg_pkg::HRI_W-1:0]  s1_held_idx;
    logic [tcdg_pkg::WR_W-1:0]   s1_set_vec;
    logic                        s1_row_written;
    logic [7:0]                  s1_glyph;
    logic [1:0]                  s1_kind;

    // Input side.
    logic                        accept;
    logic                        in_render;
    logic [tcdg_pkg::CODE_W-1:0] in_trail;
    logic                        pending_eff;
    logic [tcdg_pkg::PAIR_W-1:0] held_eff;
    logic                        in_right;

    // Stage 1 store data, with a write forwarded when it hit the read address.
    assign s1_render      = (s1_item_reg.cmd == tcdg_pkg::CMD_RENDER);
    assign s1_load_single = (s1_item_reg.cmd == tcdg_pkg::CMD_LOAD_SINGLE);
    assign s1_load_double = (s1_item_reg.cmd == tcdg_pkg::CMD_LOAD_DOUBLE);
    assign s1_row         = s1_item_reg.scanline;
    assign s1_pair        = {s1_item_reg.char_code, s1_trail_reg};
    assign pm_entry       = pm_hit_reg ? pm_fwd_reg : pm_q;
    assign sf_byte        = sf_hit_reg ? sf_fwd_reg : sf_q;
    assign df_byte        = df_hit_reg ? df_fwd_reg : df_q;
    assign s1_defined     = pm_entry[tcdg_pkg::WR_W];
    assign row_in_sf      = (s1_row < tcdg_pkg::ROW_W'(tcdg_pkg::CELL_ROWS));
    assign row_in_df      = (s1_row < tcdg_pkg::ROW_W'(tcdg_pkg::WIDE_GLYPH_ROWS));
    assign s1_wr_idx      = tcdg_pkg::WRI_W'(s1_row);
    assign s1_held_idx    = tcdg_pkg::HRI_W'(s1_row);
    assign s1_wr_bit      = s1_item_reg.half_select
                          ? tcdg_pkg::WRI_W'(tcdg_pkg::WIDE_GLYPH_ROWS) + s1_wr_idx
                          : s1_wr_idx;
    assign s1_set_vec     = row_in_df ? (tcdg_pkg::WR_W'(1) << s1_wr_bit) : '0;

    // Glyph selection: pending right half, new left half, or single-byte font.
    // A double-byte row never loaded reads as zero through its written bit.
    always_comb begin
        if (pending_reg) begin
            s1_kind        = tcdg_pkg::KIND_RIGHT;
            s1_row_written = row_in_df && held_wr_reg[s1_held_idx];
            s1_glyph       = s1_row_written ? df_byte : 8'd0;
        end else if (s1_defined) begin
            s1_kind        = tcdg_pkg::KIND_LEFT;
            s1_row_written = row_in_df && pm_entry[s1_wr_idx];
            s1_glyph       = s1_row_written ? df_byte : 8'd0;
        end else begin
            s1_kind        = tcdg_pkg::KIND_SINGLE;
            s1_row_written = 1'b0;
            s1_glyph       = row_in_sf ? sf_byte : 8'd0;
        end
    end

    assign s1_done   = s1_valid_reg && (!s1_render || out_ready);
    assign out_valid = s1_valid_reg && s1_render;
    assign out_rec   = '{glyph:  s1_glyph,
                         kind:   s1_kind,
                         attr:   s1_item_reg.attr_byte,
                         cursor: s1_item_reg.cursor_here,
                         bphase: s1_item_reg.blink_phase};

    // Write ports: clearing pass first, then loads retiring from stage 1.
    always_comb begin
        pm_we    = 1'b0;
        pm_waddr = s1_pair;
        pm_wdata = pm_entry | {s1_item_reg.mark_valid, s1_set_vec};
        sf_we    = 1'b0;
        sf_waddr = sf_addr(s1_item_reg.char_code, s1_row);
        sf_wdata = s1_item_reg.glyph_bits;
        df_we    = 1'b0;
        df_waddr = df_addr(s1_pair, s1_item_reg.half_select, s1_row);
        df_wdata = s1_item_reg.glyph_bits;
        if (!clr_done_reg) begin
            pm_we    = 1'b1;
            pm_waddr = clr_cnt_reg;
            pm_wdata = '0;
            sf_we    = (clr_cnt_reg < tcdg_pkg::PAIR_W'(tcdg_pkg::SF_DEPTH));
            sf_waddr = tcdg_pkg::SF_AW'(clr_cnt_reg);
            sf_wdata = '0;
        end else if (s1_done) begin
            pm_we = s1_load_double;
            sf_we = s1_load_single && row_in_sf;
            df_we = s1_load_double && row_in_df;
        end
    end

    // Input side: pending state after the stage 1 item retires, read addresses.
    assign in_ready  = clr_done_reg && (!s1_valid_reg || s1_done);
    assign accept    = in_valid && in_ready;
    assign in_render = (in_item.cmd == tcdg_pkg::CMD_RENDER);
    assign in_trail  = (in_render && !in_item.next_valid) ? '0 : in_item.next_code;

    always_comb begin
        pending_eff = pending_reg;
        held_eff    = held_pair_reg;
        if (s1_valid_reg && s1_render) begin
            pending_eff = !pending_reg && s1_defined;
            if (!pending_reg && s1_defined) begin
                held_eff = s1_pair;
            end
        end
    end

    assign in_right = in_render && pending_eff;
    assign pm_raddr = {in_item.char_code, in_trail};
    assign sf_raddr = sf_addr(in_item.char_code, in_item.scanline);
    assign df_raddr = in_right ? df_addr(held_eff, 1'b1, in_item.scanline)
                               : df_addr({in_item.char_code, in_trail}, 1'b0,
                                         in_item.scanline);

    // Stores.
    tcdg_ram #(.WIDTH(tcdg_pkg::PM_W), .DEPTH(tcdg_pkg::PAIR_DEPTH)) u_pair_ram (
        .aclk  (aclk),
        .we    (pm_we),
        .waddr (pm_waddr),
        .wdata (pm_wdata),
        .re    (accept),
        .raddr (pm_raddr),
        .rdata (pm_q)
    );

    tcdg_ram #(.WIDTH(8), .DEPTH(tcdg_pkg::SF_DEPTH)) u_single_ram (
        .aclk  (aclk),
        .we    (sf_we),
        .waddr (sf_waddr),
        .wdata (sf_wdata),
        .re    (accept),
        .raddr (sf_raddr),
        .rdata (sf_q)
    );

    tcdg_ram #(.WIDTH(8), .DEPTH(tcdg_pkg::DF_DEPTH)) u_double_ram (
        .aclk  (aclk),
        .we    (df_we),
        .waddr (df_waddr),
        .wdata (df_wdata),
        .re    (accept),
        .raddr (df_raddr),
        .rdata (df_q)
    );

    // Control state: clearing pass, stage valid, right-half tracking.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg   <= '0;
            clr_done_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            pending_reg   <= 1'b0;
            held_pair_reg <= '0;
            held_wr_reg   <= '0;
        end else begin
            if (!clr_done_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg) begin
                    clr_done_reg <= 1'b1;
                end
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_done) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_done && s1_render) begin
                if (pending_reg) begin
                    pending_reg <= 1'b0;
                end else if (s1_defined) begin
                    pending_reg   <= 1'b1;
                    held_pair_reg <= s1_pair;
                    held_wr_reg   <= pm_entry[tcdg_pkg::WR_W-1:tcdg_pkg::WIDE_GLYPH_ROWS];
                end
            end
            // A right-half row loaded into the held pair must be seen by its render.
            if (s1_done && s1_load_double && s1_item_reg.half_select && row_in_df
                    && (s1_pair == held_pair_reg)) begin
                held_wr_reg[s1_held_idx] <= 1'b1;
            end
        end
    end

    // Stage 1 payload and forwarding of the write that retires at the read edge.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_item_reg  <= in_item;
            s1_trail_reg <= in_trail;
            pm_hit_reg   <= pm_we && (pm_waddr == pm_raddr);
            pm_fwd_reg   <= pm_wdata;
            sf_hit_reg   <= sf_we && (sf_waddr == sf_raddr);
            sf_fwd_reg   <= sf_wdata;
            df_hit_reg   <= df_we && (df_waddr == df_raddr);
            df_fwd_reg   <= df_wdata;
        end
    end

    assign status = '{clear_done: clr_done_reg, pending: pending_reg, busy: s1_valid_reg};

endmodule

[src/tcdg_pixel.sv]
// Colour resolution, pixel expansion and the result output register.
`timescale 1ns / 1ps

module tcdg_pixel (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           rec_valid,
    output logic                           rec_ready,
    input  tcdg_pkg::glyph_rec_t           rec,
    input  logic                           blink_enable,
    input  logic                           wide_mode,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [tcdg_pkg::PIX_W-1:0]     out_pixels,
    output logic [tcdg_pkg::CNT_W-1:0]     out_count,
    output logic [1:0]                     out_kind
);

    logic [3:0]                    fg, bg;
    logic [tcdg_pkg::PIX_W-1:0]    pix;
    logic                          out_valid_reg;
    logic [tcdg_pkg::PIX_W-1:0]    pixels_reg;
    logic [tcdg_pkg::CNT_W-1:0]    count_reg;
    logic [1:0]                    kind_reg;

    // Cursor swaps colours; blink dims the background and may hide the foreground.
    always_comb begin
        if (rec.cursor) begin
            fg = rec.attr[7:4];
            bg = rec.attr[3:0];
        end else begin
            fg = rec.attr[3:0];
            bg = rec.attr[7:4];
            if (rec.attr[7] && blink_enable) begin
                bg = {1'b0, rec.attr[6:4]};
                if (rec.bphase) begin
                    fg = {1'b0, rec.attr[6:4]};
                end
            end
        end
    end

    // Bit 7 of the glyph row is pixel 0; wide mode doubles every pixel.
    always_comb begin
        pix = '0;
        for (int i = 0; i < 8; i++) begin
            if (wide_mode) begin
                pix[8*i +: 4]     = rec.glyph[7-i] ? fg : bg;
                pix[8*i + 4 +: 4] = rec.glyph[7-i] ? fg : bg;
            end else begin
                pix[4*i +: 4]     = rec.glyph[7-i] ? fg : bg;
            end
        end
    end

    assign rec_ready = !out_valid_reg || out_ready;

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (rec_ready) begin
            out_valid_reg <= rec_valid;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (rec_ready && rec_valid) begin
            pixels_reg <= pix;
            count_reg  <= wide_mode ? tcdg_pkg::WIDE_PIX : tcdg_pkg::NARROW_PIX;
            kind_reg   <= rec.kind;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_pixels = pixels_reg;
    assign out_count  = count_reg;
    assign out_kind   = kind_reg;

endmodule

[src/text_cell_dbcs_glyph_render_top.sv]
// Top level of the double-byte text glyph renderer: stream ports, APB registers, checks.
// A render beat accepted on the input passes the stage 1 register and then the result
// register that drives the output. Throughput: one beat per cycle while the result side
// does not stall; stores are read in the accept cycle and stage 1 resolves the glyph from
// the registered read data. Reset: a clearing pass over the pair table and single-byte
// font with s_axis_tready low; register writes are taken during it.
`timescale 1ns / 1ps
`include "text_cell_dbcs_glyph_render_top_defines.svh"

module text_cell_dbcs_glyph_render_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] char_code, [15:8] next_code, [16] next_valid, [24:17] attr_byte,
    // [29:25] scanline, [30] cursor_here, [31] blink_phase, [32] half_select,
    // [40:33] glyph_bits, [41] mark_valid, [47:42] zero
    input  logic [47:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_axis_tuser,
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [63:0] pixels, [68:64] pixel_count, [71:69] zero
    output logic [71:0] m_axis_tdata,
    // [1:0] double_byte_half
    output logic [1:0]  m_axis_tuser,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                          blink_enable_reg;
    logic                          wide_mode_reg;
    logic                          reg_sel;
    logic                          cfg_write;
    tcdg_pkg::item_t               in_item;
    tcdg_pkg::glyph_rec_t          rec;
    tcdg_pkg::fetch_status_t       status;
    logic                          rec_valid, rec_ready;
    logic [tcdg_pkg::PIX_W-1:0]    pixels;
    logic [tcdg_pkg::CNT_W-1:0]    pixel_count;

    // Register file: index taken from the word address.
    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_enable_reg <= 1'b0;
            wide_mode_reg    <= 1'b0;
        end else if (cfg_write) begin
            unique case (reg_sel)
                tcdg_pkg::REG_BLINK: blink_enable_reg <= pwdata[0];
                tcdg_pkg::REG_WIDE:  wide_mode_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            tcdg_pkg::REG_BLINK: prdata = {31'd0, blink_enable_reg};
            tcdg_pkg::REG_WIDE:  prdata = {31'd0, wide_mode_reg};
            default:             prdata = '0;
        endcase
    end

    // Unpack the input beat.
    assign in_item = '{cmd:         s_axis_tuser,
                       char_code:   s_axis_tdata[7:0],
                       next_code:   s_axis_tdata[15:8],
                       next_valid:  s_axis_tdata[16],
                       attr_byte:   s_axis_tdata[24:17],
                       scanline:    s_axis_tdata[29:25],
                       cursor_here: s_axis_tdata[30],
                       blink_phase: s_axis_tdata[31],
                       half_select: s_axis_tdata[32],
                       glyph_bits:  s_axis_tdata[40:33],
                       mark_valid:  s_axis_tdata[41]};

    tcdg_fetch u_fetch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .out_valid (rec_valid),
        .out_ready (rec_ready),
        .out_rec   (rec),
        .status    (status)
    );

    tcdg_pixel u_pixel (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rec_valid    (rec_valid),
        .rec_ready    (rec_ready),
        .rec          (rec),
        .blink_enable (blink_enable_reg),
        .wide_mode    (wide_mode_reg),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_pixels   (pixels),
        .out_count    (pixel_count),
        .out_kind     (m_axis_tuser)
    );

    assign m_axis_tdata = {3'd0, pixel_count, pixels};

    // No beat is taken before the clearing pass has finished.
    `TCDG_ASSERT_SAME(a_no_accept_in_clear, aclk, aresetn, !status.clear_done, !s_axis_tready, "beat accepted during clearing pass")
    // A right half can only be pending once the stores are cleared.
    `TCDG_ASSERT_SAME(a_pending_after_clear, aclk, aresetn, status.pending, status.clear_done, "right half pending before clearing pass ended")
    // An accepted beat occupies the fetch stage in the next cycle.
    `TCDG_ASSERT_NEXT(a_accept_fills_stage, aclk, aresetn, s_axis_tvalid && s_axis_tready, status.busy, "accepted beat lost before fetch stage")

endmodule

[tb/text_cell_dbcs_glyph_render_top_tb.sv]
// Self-checking testbench for the double-byte text glyph renderer.
`timescale 1ns / 1ps

module text_cell_dbcs_glyph_render_top_tb;
    import tcdg_pkg::*;

    // The fourth command code is unused and must be ignored by the block.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_PHASES = 6;
    localparam int BEATS_PER_PHASE = 260;
    localparam int LONG_HOLD = 300;
    localparam int SETTLE_CYCLES = 8;

    // Expected render result: pixels, pixel count and glyph half.
    typedef struct packed {
        logic [PIX_W-1:0] pixels;
        logic [CNT_W-1:0] count;
        logic [1:0]       kind;
    } cell_row_t;

    // Tracks font contents, pair marks and the held pair, and predicts rendered rows.
    class cell_row_board;
        bit [7:0]    narrow_glyphs [256*CELL_ROWS];
        bit [7:0]    wide_glyphs [int unsigned];
        bit          pair_marks [int unsigned];
        bit          right_pending;
        logic [7:0]  held_lead;
        logic [7:0]  held_trail;
        bit          blink_on;
        bit          wide_on;
        cell_row_t   expected_rows [$];
        int          mismatches;

        function new();
            right_pending = 1'b0;
            held_lead = '0;
            held_trail = '0;
            blink_on = 1'b0;
            wide_on = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] value);
            if (idx == REG_BLINK) begin
                blink_on = value[0];
            end else begin
                wide_on = value[0];
            end
        endfunction

        function int unsigned wide_slot(int unsigned lead, int unsigned trail,
                                        int unsigned half, int unsigned row);
            return ((lead * 256 + trail) * 2 + half) * WIDE_GLYPH_ROWS + row;
        endfunction

        // Double-byte rows past the font height read as blank.
        function bit [7:0] wide_row(int unsigned lead, int unsigned trail,
                                    int unsigned half, int unsigned row);
            int unsigned slot;
            if (row >= WIDE_GLYPH_ROWS) return 8'h00;
            slot = wide_slot(lead, trail, half, row);
            return wide_glyphs.exists(slot) ? wide_glyphs[slot] : 8'h00;
        endfunction

        // Applies one accepted beat and queues the row it renders, if any.
        function void take_beat(item_t b);
            int unsigned trail;
            bit [7:0]    bits;
            logic [1:0]  kind;
            logic [3:0]  fg;
            logic [3:0]  bg;
            logic [3:0]  c;
            cell_row_t   row;
            case (b.cmd)
                CMD_LOAD_SINGLE: begin
                    if (b.scanline < CELL_ROWS)
                        narrow_glyphs[b.char_code * CELL_ROWS + b.scanline] = b.glyph_bits;
                end
                CMD_LOAD_DOUBLE: begin
                    if (b.scanline < WIDE_GLYPH_ROWS)
                        wide_glyphs[wide_slot(b.char_code, b.next_code, b.half_select,
                                              b.scanline)] = b.glyph_bits;
                    if (b.mark_valid) pair_marks[{b.char_code, b.next_code}] = 1'b1;
                end
                CMD_RENDER: begin
                    // Pick the glyph: pending right half, new left half, or single byte.
                    if (right_pending) begin
                        kind = KIND_RIGHT;
                        bits = wide_row(held_lead, held_trail, 1, b.scanline);
                        right_pending = 1'b0;
                    end else begin
                        trail = b.next_valid ? b.next_code : 0;
                        if (pair_marks.exists({b.char_code, trail[7:0]})) begin
                            kind = KIND_LEFT;
                            held_lead = b.char_code;
                            held_trail = trail[7:0];
                            right_pending = 1'b1;
                            bits = wide_row(b.char_code, trail, 0, b.scanline);
                        end else begin
                            kind = KIND_SINGLE;
                            bits = (b.scanline < CELL_ROWS) ?
                                   narrow_glyphs[b.char_code * CELL_ROWS + b.scanline] : 8'h00;
                        end
                    end
                    // Cursor swaps the colors; otherwise blink may dim and hide.
                    if (b.cursor_here) begin
                        bg = b.attr_byte[3:0];
                        fg = b.attr_byte[7:4];
                    end else begin
                        fg = b.attr_byte[3:0];
                        bg = b.attr_byte[7:4];
                        if (b.attr_byte[7] && blink_on) begin
                            bg = {1'b0, b.attr_byte[6:4]};
                            if (b.blink_phase) fg = bg;
                        end
                    end
                    row.pixels = '0;
                    for (int i = 0; i < 8; i++) begin
                        c = bits[7-i] ? fg : bg;
                        if (wide_on) begin
                            row.pixels[8*i +: 4] = c;
                            row.pixels[8*i+4 +: 4] = c;
                        end else begin
                            row.pixels[4*i +: 4] = c;
                        end
                    end
                    row.count = wide_on ? WIDE_PIX : NARROW_PIX;
                    row.kind = kind;
                    expected_rows.push_back(row);
                end
                default: ;
            endcase
        endfunction

        function void report(string what, cell_row_t want, cell_row_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] %s: expected pixels %h count %0d half %0d, got %h %0d %0d",
                         $time, what, want.pixels, want.count, want.kind,
                         got.pixels, got.count, got.kind);
        endfunction

        // Compares a result beat with the oldest expected row.
        function void check_row(cell_row_t got);
            cell_row_t want;
            if (expected_rows.size() == 0) begin
                report("result with nothing expected", '0, got);
                return;
            end
            want = expected_rows.pop_front();
            if (got.pixels !== want.pixels) report("pixel mismatch", want, got);
            else if (got.count !== want.count) report("pixel count mismatch", want, got);
            else if (got.kind !== want.kind) report("glyph half mismatch", want, got);
        endfunction

        function int outstanding();
            return expected_rows.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    cell_row_board board = new();
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_requests = 0;
    int holds_taken = 0;
    int hold_left = 0;

    text_cell_dbcs_glyph_render_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: check each accepted beat, then decide the next ready.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_row({m_axis_tdata[63:0], m_axis_tdata[68:64], m_axis_tuser});
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (holds_taken != hold_requests) begin
                holds_taken = hold_requests;
                hold_left = LONG_HOLD;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Run limit, well above the slowest correct run including the clearing pass.
    initial begin
        #8000000;
        $display("text_cell_dbcs_glyph_render_top regression: fail");
        $finish;
    end

    function automatic item_t make_beat(logic [1:0] cmd, logic [7:0] code, logic [7:0] nxt,
                                        logic nvalid, logic [7:0] attr, logic [4:0] row,
                                        logic cursor, logic bphase, logic half,
                                        logic [7:0] bits, logic mark);
        item_t b;
        b.cmd = cmd;
        b.char_code = code;
        b.next_code = nxt;
        b.next_valid = nvalid;
        b.attr_byte = attr;
        b.scanline = row;
        b.cursor_here = cursor;
        b.blink_phase = bphase;
        b.half_select = half;
        b.glyph_bits = bits;
        b.mark_valid = mark;
        return b;
    endfunction

    // Codes are mostly drawn from small pools so that loads and renders meet.
    function automatic logic [7:0] pick_code(bit lead);
        logic [7:0] leads [6] = '{8'h81, 8'h9F, 8'hE0, 8'hFC, 8'h00, 8'hFF};
        logic [7:0] trails [6] = '{8'h40, 8'h7E, 8'h80, 8'hFC, 8'h00, 8'hFF};
        if ($urandom_range(99) < 30) return 8'($urandom_range(255));
        return lead ? leads[$urandom_range(5)] : trails[$urandom_range(5)];
    endfunction

    function automatic item_t random_beat();
        item_t b;
        int    roll;
        b = make_beat(CMD_RENDER, pick_code(1'b1), pick_code(1'b0),
                      ($urandom_range(99) < 80), 8'($urandom_range(255)),
                      5'($urandom_range(CELL_ROWS - 1)), ($urandom_range(99) < 15),
                      1'($urandom_range(1)), 1'($urandom_range(1)),
                      8'($urandom_range(255)), 1'($urandom_range(1)));
        roll = $urandom_range(99);
        if (roll < 15) b.cmd = CMD_LOAD_SINGLE;
        else if (roll < 37) b.cmd = CMD_LOAD_DOUBLE;
        else if (roll < 40) b.cmd = CMD_UNUSED;
        return b;
    endfunction

    // Offers one input beat and waits until the block takes it.
    task automatic send_beat(item_t b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, b.mark_valid, b.glyph_bits, b.half_select, b.blink_phase,
                         b.cursor_here, b.scanline, b.attr_byte, b.next_valid,
                         b.next_code, b.char_code};
        s_axis_tuser <= b.cmd;
        do @(posedge aclk); while (!s_axis_tready);
        board.take_beat(b);
    endtask

    // Register write: setup phase, access phase until pready, then back to idle.
    task automatic reg_write(logic idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        board.set_reg(idx, value);
    endtask

    task automatic wait_idle();
        while (board.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        bit blink_set [RANDOM_PHASES] = '{1, 0, 1, 0, 1, 1};
        bit wide_set [RANDOM_PHASES] = '{0, 1, 1, 0, 1, 0};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed beats with both registers at their reset value.
        send_beat(make_beat(CMD_RENDER, 8'h00, 8'h00, 0, 8'h00, 0, 0, 0, 0, 8'h00, 0));
        send_beat(make_beat(CMD_LOAD_SINGLE, 8'h41, 8'h00, 0, 8'h00, 0, 0, 0, 0, 8'hA5, 0));
        send_beat(make_beat(CMD_RENDER, 8'h41, 8'h00, 0, 8'h1E, 0, 0, 0, 0, 8'h00, 0));
        send_beat(make_beat(CMD_LOAD_SINGLE, 8'hFF, 8'h00, 0, 8'h00, 18, 0, 0, 0, 8'hFF, 0));
        send_beat(make_beat(CMD_RENDER, 8'hFF, 8'hFF, 1, 8'hF0, 18, 1, 1, 0, 8'h00, 0));
        // A defined pair draws its left half, then the right half whatever the next code.
        send_beat(make_beat(CMD_LOAD_DOUBLE, 8'h81, 8'h40, 0, 8'h00, 0, 0, 0, 0, 8'hF0, 1));
        send_beat(make_beat(CMD_LOAD_DOUBLE, 8'h81, 8'h40, 0, 8'h00, 0, 0, 0, 1, 8'h0F, 0));
        send_beat(make_beat(CMD_RENDER, 8'h81, 8'h40, 1, 8'h8C, 0, 0, 1, 0, 8'h00, 0));
        send_beat(make_beat(CMD_RENDER, 8'h20, 8'h00, 0, 8'h8C, 0, 0, 0, 0, 8'h00, 0));
        // Without a following cell the lookup uses trail code zero.
        send_beat(make_beat(CMD_RENDER, 8'h81, 8'h40, 0, 8'h7A, 0, 0, 0, 0, 8'h00, 0));
        // A load past the font height is dropped but its mark still takes effect.
        send_beat(make_beat(CMD_LOAD_DOUBLE, 8'h82, 8'h00, 0, 8'h00, 17, 0, 0, 0, 8'hFF, 1));
        send_beat(make_beat(CMD_RENDER, 8'h82, 8'h55, 0, 8'h3C, 17, 0, 0, 0, 8'h00, 0));
        send_beat(make_beat(CMD_RENDER, 8'h82, 8'h55, 0, 8'h3C, 17, 0, 0, 0, 8'h00, 0));
        // A load without a mark leaves the existing mark in place.
        send_beat(make_beat(CMD_LOAD_DOUBLE, 8'h82, 8'h00, 0, 8'h00, 3, 0, 0, 0, 8'h3C, 0));
        send_beat(make_beat(CMD_RENDER, 8'h82, 8'h00, 0, 8'h52, 3, 0, 0, 0, 8'h00, 0));
        // Loads and the unused command between halves keep the right half pending.
        send_beat(make_beat(CMD_LOAD_SINGLE, 8'h82, 8'h00, 0, 8'h00, 3, 0, 0, 0, 8'h81, 0));
        send_beat(make_beat(CMD_UNUSED, 8'hFF, 8'hFF, 1, 8'hFF, 31, 1, 1, 1, 8'hFF, 1));
        send_beat(make_beat(CMD_RENDER, 8'h00, 8'h00, 1, 8'hFF, 3, 0, 1, 0, 8'h00, 0));
        send_beat(make_beat(CMD_RENDER, 8'h82, 8'h01, 1, 8'hFF, 3, 1, 0, 0, 8'h00, 0));
        send_beat(make_beat(CMD_RENDER, 8'hFF, 8'h00, 1, 8'h80, 18, 0, 1, 0, 8'h00, 0));
        s_axis_tvalid <= 1'b0;
        wait_idle();

        // Random phases, each under its own register setting and idle pattern.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            reg_write(REG_BLINK, {31'b0, blink_set[p]});
            reg_write(REG_WIDE, {31'b0, wide_set[p]});
            if (p < 2) begin
                tx_idle_pct = 14;
                rx_idle_pct <= 76;
            end else if (p < 4) begin
                tx_idle_pct = 76;
                rx_idle_pct <= 14;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                // Long receiver hold while the sender keeps offering beats.
                if (p == 4 && n == 30) hold_requests <= hold_requests + 1;
                send_beat(random_beat());
            end
            s_axis_tvalid <= 1'b0;
            wait_idle();
        end

        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("text_cell_dbcs_glyph_render_top regression: pass");
        else
            $display("text_cell_dbcs_glyph_render_top regression: fail");
        $finish;
    end

endmodule
